@@ hw/rtl/cew_pkg.sv @@
`default_nettype none
package cew_pkg;

    localparam int unsigned WeightWidth = 16;
    localparam int unsigned CodePointWidth = 21;

    typedef logic [WeightWidth-1:0] weight_t;
    typedef logic [CodePointWidth-1:0] code_point_t;

    localparam weight_t SEC_COMMON = 16'h0020;
    localparam weight_t TER_COMMON = 16'h0002;
    localparam weight_t QUAT_FULL = 16'hFFFF;
    localparam weight_t TRAIL_FLAG = 16'h8000;
    localparam weight_t OFFSET_MASK = 16'h7FFF;

    localparam weight_t LEAD_TANGUT = 16'hFB00;
    localparam weight_t LEAD_NUSHU = 16'hFB01;
    localparam weight_t LEAD_KHITAN = 16'hFB02;
    localparam weight_t BASE_CORE_CJK = 16'hFB40;
    localparam weight_t BASE_OTHER_IDEO = 16'hFB80;
    localparam weight_t BASE_UNASSIGNED = 16'hFBC0;

    localparam code_point_t TANGUT_ORIGIN = 21'h17000;
    localparam code_point_t NUSHU_ORIGIN = 21'h1B170;
    localparam code_point_t KHITAN_ORIGIN = 21'h18B00;
    localparam code_point_t COMPAT_ORIGIN = 21'h0FA0E;
    localparam code_point_t COMPAT_END = 21'h0FA29;

    // bit k set: FA0E+k is a unified ideograph
    localparam logic [27:0] COMPAT_UNIFIED_MASK = 28'h0E6A006B;

    typedef struct packed {
        weight_t lead;
        weight_t trail;
    } implicit_t;

endpackage
`default_nettype wire

@@ hw/rtl/cew_if.sv @@
`default_nettype none
interface cew_in_if;
    import cew_pkg::*;

    logic valid;
    logic ready;
    logic mode;
    weight_t weight_primary;
    weight_t weight_secondary;
    weight_t weight_tertiary;
    code_point_t code_point;

    modport source (
        output valid, mode, weight_primary, weight_secondary, weight_tertiary, code_point,
        input ready
    );
    modport sink (
        input valid, mode, weight_primary, weight_secondary, weight_tertiary, code_point,
        output ready
    );
endinterface

interface cew_out_if;
    import cew_pkg::*;

    logic valid;
    logic ready;
    weight_t out_primary;
    weight_t out_secondary;
    weight_t out_tertiary;
    weight_t out_quaternary;
    logic last;

    modport source (
        output valid, out_primary, out_secondary, out_tertiary, out_quaternary, last,
        input ready
    );
    modport sink (
        input valid, out_primary, out_secondary, out_tertiary, out_quaternary, last,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/collation_element_weighting.sv @@
`default_nettype none
// Collation element weighting: each item is either an explicit three-level
// weight triple, turned into one four-level element by the shifted rule, or a
// code point, turned into the two implicit weight elements (the second one
// carries last). Items pass through a holding register and then a result
// register. While the output is not stalled, a new explicit item is accepted
// every cycle; a code point item occupies the holding register until both of
// its elements are written, as the output register takes a single write per
// cycle. highest_variable is to be written through cfg_we/cfg_wdata only
// while the block is idle, which the user must ensure and the block does not
// enforce; it resets to 0, which makes no primary variable.
module collation_element_weighting (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire cew_pkg::weight_t  cfg_wdata,
    cew_in_if.sink                 in_ch,
    cew_out_if.source              out_ch
);
    import cew_pkg::*;

    logic        hold_valid_reg;
    logic        phase_reg;
    logic        after_var_reg;
    weight_t     highest_var_reg;
    logic        hold_mode_reg;
    weight_t     hold_pri_reg;
    weight_t     hold_sec_reg;
    weight_t     hold_ter_reg;
    code_point_t hold_cp_reg;

    logic        out_valid_reg;
    weight_t     out_pri_reg;
    weight_t     out_sec_reg;
    weight_t     out_ter_reg;
    weight_t     out_quat_reg;
    logic        out_last_reg;

    weight_t     pri_next;
    weight_t     sec_next;
    weight_t     ter_next;
    weight_t     quat_next;
    logic        last_next;
    logic        after_var_next;

    logic        out_free;
    logic        emit;
    logic        done;
    logic        in_accept;
    logic        in_var_range;
    implicit_t   implicit_w;

    cew_implicit u_implicit (
        .code_point (hold_cp_reg),
        .weights    (implicit_w)
    );

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign emit      = hold_valid_reg && out_free;
    assign done      = emit && (!hold_mode_reg || phase_reg);
    assign in_ch.ready = !hold_valid_reg || done;
    assign in_accept = in_ch.valid && in_ch.ready;

    assign in_var_range = hold_pri_reg >= 16'd2 && hold_pri_reg <= highest_var_reg;

    always_comb
    begin
        pri_next       = hold_pri_reg;
        sec_next       = hold_sec_reg;
        ter_next       = hold_ter_reg;
        quat_next      = (hold_ter_reg == '0) ? '0 : QUAT_FULL;
        last_next      = 1'b1;
        after_var_next = 1'b0;
        if (hold_mode_reg)
        begin
            if (!phase_reg)
            begin
                pri_next  = implicit_w.lead;
                sec_next  = SEC_COMMON;
                ter_next  = TER_COMMON;
                quat_next = QUAT_FULL;
                last_next = 1'b0;
            end
            else
            begin
                pri_next  = implicit_w.trail;
                sec_next  = '0;
                ter_next  = '0;
                quat_next = '0;
            end
        end
        else if (in_var_range)
        begin
            pri_next       = '0;
            sec_next       = '0;
            ter_next       = '0;
            quat_next      = hold_pri_reg;
            after_var_next = 1'b1;
        end
        // ignorable right after a variable is dropped to all zeros
        else if (after_var_reg && hold_pri_reg == '0 && hold_ter_reg != '0)
        begin
            pri_next  = '0;
            sec_next  = '0;
            ter_next  = '0;
            quat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            phase_reg       <= 1'b0;
            after_var_reg   <= 1'b0;
            highest_var_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                highest_var_reg <= cfg_wdata;
            end
            if (in_accept)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (done)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (done)
            begin
                phase_reg <= 1'b0;
            end
            else if (emit)
            begin
                phase_reg <= 1'b1;
            end
            if (emit)
            begin
                after_var_reg <= after_var_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_mode_reg <= in_ch.mode;
            hold_pri_reg  <= in_ch.weight_primary;
            hold_sec_reg  <= in_ch.weight_secondary;
            hold_ter_reg  <= in_ch.weight_tertiary;
            hold_cp_reg   <= in_ch.code_point;
        end
        if (emit)
        begin
            out_pri_reg  <= pri_next;
            out_sec_reg  <= sec_next;
            out_ter_reg  <= ter_next;
            out_quat_reg <= quat_next;
            out_last_reg <= last_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_primary    = out_pri_reg;
    assign out_ch.out_secondary  = out_sec_reg;
    assign out_ch.out_tertiary   = out_ter_reg;
    assign out_ch.out_quaternary = out_quat_reg;
    assign out_ch.last           = out_last_reg;

endmodule
`default_nettype wire

@@ hw/rtl/cew_implicit.sv @@
`default_nettype none
module cew_implicit (
    input  wire cew_pkg::code_point_t code_point,
    output cew_pkg::implicit_t        weights
);
    import cew_pkg::*;

    logic        is_tangut;
    logic        is_nushu;
    logic        is_khitan;
    logic        is_compat;
    logic        is_core_cjk;
    logic        is_other_ideo;
    logic [4:0]  compat_idx;
    code_point_t compat_diff;
    code_point_t offset;
    weight_t     block_bits;

    assign is_tangut = (code_point >= 21'h17000 && code_point <= 21'h18AFF)
                    || (code_point >= 21'h18D00 && code_point <= 21'h18D8F);
    assign is_nushu  = code_point >= 21'h1B170 && code_point <= 21'h1B2FF;
    assign is_khitan = code_point >= 21'h18B00 && code_point <= 21'h18CFF;

    assign is_compat   = code_point >= COMPAT_ORIGIN && code_point <= COMPAT_END;
    assign compat_diff = code_point - COMPAT_ORIGIN;
    assign compat_idx  = compat_diff[4:0];

    assign is_core_cjk = (code_point >= 21'h04E00 && code_point <= 21'h09FFF)
                      || (is_compat && COMPAT_UNIFIED_MASK[compat_idx]);

    assign is_other_ideo = (code_point >= 21'h03400 && code_point <= 21'h04DBF)
                        || (code_point >= 21'h20000 && code_point <= 21'h2A6DF)
                        || (code_point >= 21'h2A700 && code_point <= 21'h2B739)
                        || (code_point >= 21'h2B740 && code_point <= 21'h2B81D)
                        || (code_point >= 21'h2B820 && code_point <= 21'h2CEA1)
                        || (code_point >= 21'h2CEB0 && code_point <= 21'h2EBE0)
                        || (code_point >= 21'h30000 && code_point <= 21'h3134A)
                        || (code_point >= 21'h31350 && code_point <= 21'h323AF);

    // block number goes into the low bits of the lead weight
    assign block_bits = {10'd0, code_point[20:15]};

    always_comb
    begin
        weights = '0;
        priority if (is_tangut)
        begin
            weights.lead = LEAD_TANGUT;
            offset       = code_point - TANGUT_ORIGIN;
        end
        else if (is_nushu)
        begin
            weights.lead = LEAD_NUSHU;
            offset       = code_point - NUSHU_ORIGIN;
        end
        else if (is_khitan)
        begin
            weights.lead = LEAD_KHITAN;
            offset       = code_point - KHITAN_ORIGIN;
        end
        else if (is_core_cjk)
        begin
            weights.lead = BASE_CORE_CJK + block_bits;
            offset       = code_point;
        end
        else if (is_other_ideo)
        begin
            weights.lead = BASE_OTHER_IDEO + block_bits;
            offset       = code_point;
        end
        else
        begin
            weights.lead = BASE_UNASSIGNED + block_bits;
            offset       = code_point;
        end
        weights.trail = TRAIL_FLAG | (offset[15:0] & OFFSET_MASK);
    end

endmodule
`default_nettype wire
